@@ rtl/thumb_fetch_branch_forward_assert.svh @@
// Assertion macros for the Thumb fetch block.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef THUMB_FETCH_BRANCH_FORWARD_ASSERT_SVH
`define THUMB_FETCH_BRANCH_FORWARD_ASSERT_SVH
`ifndef ASSERT_OFF
// checked out of reset only
`define TFBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked during reset as well
`define TFBF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TFBF_ASSERT(lbl, prop, msg)
`define TFBF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/tfbf_pkg.sv @@
// Shared types and constants for the Thumb fetch block.
// No dependencies.
package tfbf_pkg;

  typedef enum logic [1:0] {
    ST_FETCHED  = 2'd0,
    ST_HAZARD   = 2'd1,
    ST_ARM_MODE = 2'd2
  } status_e;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_START_PC    = 2'd0;
  localparam cfg_idx_t CFG_HAZARD_PC   = 2'd1;
  localparam cfg_idx_t CFG_HAZARD_INST = 2'd2;

  localparam logic [31:0] HAZARD_LIMIT = 32'hf000_0000;

  // B T4 / BL T1 encodings: ones mask and zeros mask
  localparam logic [31:0] B_T4_ONES  = 32'hf000_9000;
  localparam logic [31:0] B_T4_ZEROS = 32'h0800_4000;
  localparam logic [31:0] BL_T1_ONES  = 32'hf000_d000;
  localparam logic [31:0] BL_T1_ZEROS = 32'h0800_0000;
  // B T2 and BX T1 on the halfword
  localparam logic [15:0] B_T2_ONES  = 16'he000;
  localparam logic [15:0] B_T2_ZEROS = 16'h1000;
  localparam logic [15:0] BX_T1_ONES  = 16'h4700;
  localparam logic [15:0] BX_T1_ZEROS = 16'hb880;

  localparam logic [31:0] BL_SIGN_FILL = 32'hff00_0000;
  localparam logic [31:0] BT2_SIGN_FILL = 32'hffff_f000;
  localparam logic [15:0] TOP5_MASK = 16'hf800;

  typedef struct packed {
    status_e     status;
    logic [31:0] fetched_inst;
    logic [31:0] inst_pc;
    logic        is_wide;
    logic [31:0] next_pc;
  } rsp_t;

  typedef struct packed {
    logic        thumb_mode;
    logic [15:0] first_half;
    logic [15:0] second_half;
    logic [31:0] reg_value;
  } req_t;

endpackage

@@ rtl/tfbf_req_if.sv @@
// Fetch request channel: T bit, two halfwords and a register value.
// Depends on nothing.
interface tfbf_req_if;
  logic        valid;
  logic        ready;
  logic        thumb_mode;
  logic [15:0] first_half;
  logic [15:0] second_half;
  logic [31:0] reg_value;

  modport source (output valid, thumb_mode, first_half, second_half, reg_value,
                  input ready);
  modport sink (input valid, thumb_mode, first_half, second_half, reg_value,
                output ready);
endinterface

@@ rtl/tfbf_rsp_if.sv @@
// Fetch result channel towards decode.
// Depends on tfbf_pkg for the status type.
interface tfbf_rsp_if;
  logic              valid;
  logic              ready;
  tfbf_pkg::status_e status;
  logic [31:0]       fetched_inst;
  logic [31:0]       inst_pc;
  logic              is_wide;
  logic [31:0]       next_pc;

  modport source (output valid, status, fetched_inst, inst_pc, is_wide, next_pc,
                  input ready);
  modport sink (input valid, status, fetched_inst, inst_pc, is_wide, next_pc,
                output ready);
endinterface

@@ rtl/thumb_fetch_branch_forward.sv @@
// Channel   Dir  Handshake        Payload
// req_i     in   valid/ready      thumb_mode, first_half, second_half, reg_value
// rsp_o     out  valid/ready      status, fetched_inst, inst_pc, is_wide, next_pc
// cfg       in   cfg_we_i only    cfg_idx_i, cfg_data_i
//
// One request per cycle sustained while the result is not stalled.
// Decode of the held request and the PC update sit between the input register
// and the result register; the PC register closes the loop.
// Reset clears valids and loads the PC with zero; a start_pc write reloads it.
// A stalled result keeps the request register full; ready drops only then.
//
// Depends on tfbf_pkg, tfbf_req_if, tfbf_rsp_if and the assertion header.
`include "thumb_fetch_branch_forward_assert.svh"

module thumb_fetch_branch_forward (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  tfbf_pkg::cfg_idx_t cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  tfbf_req_if.sink           req_i,
  tfbf_rsp_if.source         rsp_o
);

  logic            req_valid_q;
  tfbf_pkg::req_t  req_q;
  logic            rsp_valid_q;
  tfbf_pkg::rsp_t  rsp_q, rsp_d;
  logic [31:0]     pc_q;
  logic [31:0]     start_pc_q, hazard_pc_q, hazard_inst_q;
  logic            advance;
  logic            req_take;

  assign advance  = req_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !req_valid_q || advance;
  assign req_take = req_i.valid && req_i.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      req_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      req_q.thumb_mode  <= req_i.thumb_mode;
      req_q.first_half  <= req_i.first_half;
      req_q.second_half <= req_i.second_half;
      req_q.reg_value   <= req_i.reg_value;
    end
  end

  // decode, branch folding and next PC
  logic [31:0] base_pc;
  logic [31:0] word;
  logic        wide;
  logic [15:0] top5;
  logic        s_bit;
  logic [31:0] long_off;
  logic [31:0] short_off;

  always_comb begin
    base_pc = pc_q + 32'd4;
    top5    = req_q.first_half & tfbf_pkg::TOP5_MASK;
    wide    = (top5 == 16'he800) || (top5 == 16'hf000) || (top5 == 16'hf800);
    word    = wide ? {req_q.first_half, req_q.second_half} : {16'h0000, req_q.first_half};

    // S taken from bit 26 of the word
    s_bit    = word[26];
    long_off = {8'h00, ~(word[13] ^ s_bit), ~(word[11] ^ s_bit),
                word[25:16], word[10:0], 1'b0};
    if (s_bit) begin
      long_off = long_off | tfbf_pkg::BL_SIGN_FILL;
    end
    short_off = {20'h00000, word[10:0], 1'b0};
    if (word[10]) begin
      short_off = short_off | tfbf_pkg::BT2_SIGN_FILL;
    end

    rsp_d.status       = tfbf_pkg::ST_FETCHED;
    rsp_d.fetched_inst = word;
    rsp_d.inst_pc      = base_pc;
    rsp_d.is_wide      = wide;
    rsp_d.next_pc      = pc_q + (wide ? 32'd4 : 32'd2);

    if (wide) begin
      if ((word & (tfbf_pkg::B_T4_ONES | tfbf_pkg::B_T4_ZEROS)) == tfbf_pkg::B_T4_ONES ||
          (word & (tfbf_pkg::BL_T1_ONES | tfbf_pkg::BL_T1_ZEROS)) == tfbf_pkg::BL_T1_ONES)
      begin
        rsp_d.next_pc = base_pc + long_off;
      end
    end else begin
      if ((req_q.first_half & (tfbf_pkg::B_T2_ONES | tfbf_pkg::B_T2_ZEROS)) ==
          tfbf_pkg::B_T2_ONES) begin
        rsp_d.next_pc = base_pc + short_off;
      end else if ((req_q.first_half & (tfbf_pkg::BX_T1_ONES | tfbf_pkg::BX_T1_ZEROS)) ==
                   tfbf_pkg::BX_T1_ONES) begin
        rsp_d.next_pc = {req_q.reg_value[31:1], 1'b0};
      end
    end

    // hazard wins over the T bit
    if (pc_q > tfbf_pkg::HAZARD_LIMIT) begin
      rsp_d.status       = tfbf_pkg::ST_HAZARD;
      rsp_d.fetched_inst = hazard_inst_q;
      rsp_d.inst_pc      = hazard_pc_q;
      rsp_d.is_wide      = 1'b0;
      rsp_d.next_pc      = hazard_pc_q;
    end else if (!req_q.thumb_mode) begin
      rsp_d.status       = tfbf_pkg::ST_ARM_MODE;
      rsp_d.fetched_inst = 32'h0;
      rsp_d.inst_pc      = 32'h0;
      rsp_d.is_wide      = 1'b0;
      rsp_d.next_pc      = pc_q;
    end
  end

  // PC and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q          <= 32'h0;
      start_pc_q    <= 32'h0;
      hazard_pc_q   <= 32'h0;
      hazard_inst_q <= 32'h0;
    end else begin
      if (advance) begin
        pc_q <= rsp_d.next_pc;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tfbf_pkg::CFG_START_PC: begin
            start_pc_q <= cfg_data_i;
            pc_q       <= cfg_data_i;
          end
          tfbf_pkg::CFG_HAZARD_PC: begin
            hazard_pc_q <= cfg_data_i;
          end
          tfbf_pkg::CFG_HAZARD_INST: begin
            hazard_inst_q <= cfg_data_i;
          end
          default: begin
            start_pc_q <= start_pc_q;
          end
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_q.status;
  assign rsp_o.fetched_inst = rsp_q.fetched_inst;
  assign rsp_o.inst_pc      = rsp_q.inst_pc;
  assign rsp_o.is_wide      = rsp_q.is_wide;
  assign rsp_o.next_pc      = rsp_q.next_pc;

  // the PC follows the result just registered
  `TFBF_ASSERT(a_pc_follows, advance && !cfg_we_i |=> pc_q == rsp_q.next_pc, "pc out of step with result")
  `TFBF_ASSERT(a_hazard_pc, rsp_valid_q && rsp_q.status == tfbf_pkg::ST_HAZARD |-> rsp_q.next_pc == rsp_q.inst_pc && !rsp_q.is_wide, "hazard result inconsistent")
  `TFBF_ASSERT(a_arm_zero, rsp_valid_q && rsp_q.status == tfbf_pkg::ST_ARM_MODE |-> rsp_q.fetched_inst == 32'h0 && !rsp_q.is_wide, "arm result not cleared")
  `TFBF_ASSERT(a_wide_fetched, rsp_valid_q && rsp_q.is_wide |-> rsp_q.status == tfbf_pkg::ST_FETCHED, "wide flag on non-fetch result")
  `TFBF_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !rsp_valid_q && !req_valid_q, "valid during reset")

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for thumb_fetch_branch_forward: directed and random fetch requests,
// an in-bench predictor of the fetch PC, and a scoreboard on the result channel.
// Depends on tfbf_pkg, tfbf_req_if, tfbf_rsp_if and the block itself.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam tfbf_pkg::cfg_idx_t CFG_UNUSED = 2'd3;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  tfbf_pkg::cfg_idx_t cfg_idx_i;
  logic [31:0]        cfg_data_i;

  tfbf_req_if req_if ();
  tfbf_rsp_if rsp_if ();

  thumb_fetch_branch_forward u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // predictor state, mirrors the block's registers
  logic [31:0] model_pc;
  logic [31:0] cfg_start_pc;
  logic [31:0] cfg_hazard_pc;
  logic [31:0] cfg_hazard_inst;

  tfbf_pkg::req_t fetch_queue[$];
  tfbf_pkg::rsp_t predicted_results[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          req_taken;
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_accepted;
  int unsigned n_checked;
  int unsigned n_hazard;
  int unsigned n_arm;
  int unsigned n_redirect;
  int unsigned n_wide;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic has_bits(input logic [31:0] w, input logic [31:0] ones,
                                    input logic [31:0] zeros);
    return ((w & ones) == ones) && ((~w & zeros) == zeros);
  endfunction

  // Works out the result of one fetch and advances the predicted PC.
  function automatic tfbf_pkg::rsp_t predict_fetch(input tfbf_pkg::req_t rq);
    tfbf_pkg::rsp_t r;
    logic [31:0]    base;
    logic [31:0]    word;
    logic [31:0]    off;
    logic [31:0]    seq_pc;
    logic           s;
    logic           wide;
    r = '0;
    base = model_pc + 32'd4;
    if (model_pc > tfbf_pkg::HAZARD_LIMIT) begin
      r.status       = tfbf_pkg::ST_HAZARD;
      r.fetched_inst = cfg_hazard_inst;
      r.inst_pc      = cfg_hazard_pc;
      r.next_pc      = cfg_hazard_pc;
      model_pc       = cfg_hazard_pc;
      n_hazard++;
      return r;
    end
    if (!rq.thumb_mode) begin
      r.status  = tfbf_pkg::ST_ARM_MODE;
      r.next_pc = model_pc;
      n_arm++;
      return r;
    end
    wide = (rq.first_half[15:11] == 5'b11101) || (rq.first_half[15:11] == 5'b11110) ||
           (rq.first_half[15:11] == 5'b11111);
    if (wide) begin
      word = {rq.first_half, rq.second_half};
      seq_pc = model_pc + 32'd4;
      r.next_pc = seq_pc;
      if (has_bits(word, tfbf_pkg::B_T4_ONES, tfbf_pkg::B_T4_ZEROS) ||
          has_bits(word, tfbf_pkg::BL_T1_ONES, tfbf_pkg::BL_T1_ZEROS))
      begin
        // sign taken from bit 26, I1/I2 rebuilt from J1/J2
        s = word[26];
        off = {{8{s}}, ~(word[13] ^ s), ~(word[11] ^ s), word[25:16], word[10:0], 1'b0};
        r.next_pc = base + off;
      end
      n_wide++;
    end else begin
      word = {16'h0000, rq.first_half};
      seq_pc = model_pc + 32'd2;
      r.next_pc = seq_pc;
      if (has_bits(word, {16'h0, tfbf_pkg::B_T2_ONES}, {16'h0, tfbf_pkg::B_T2_ZEROS})) begin
        r.next_pc = base + {{20{word[10]}}, word[10:0], 1'b0};
      end else if (has_bits(word, {16'h0, tfbf_pkg::BX_T1_ONES},
                            {16'h0, tfbf_pkg::BX_T1_ZEROS})) begin
        r.next_pc = {rq.reg_value[31:1], 1'b0};
      end
    end
    if (r.next_pc != seq_pc) n_redirect++;
    r.status       = tfbf_pkg::ST_FETCHED;
    r.fetched_inst = word;
    r.inst_pc      = base;
    r.is_wide      = wide;
    model_pc       = r.next_pc;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: result %0d %s mismatch: got %08h, expected %08h",
             $time, n_checked, field, got, want);
    n_errors++;
  endtask

  // Request and result sampling at the rising edge.
  always @(posedge clk_i) begin
    tfbf_pkg::rsp_t want;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        req_taken = 1'b1;
        predicted_results.push_back(predict_fetch({req_if.thumb_mode, req_if.first_half,
                                                   req_if.second_half, req_if.reg_value}));
        n_accepted++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected result", rsp_if.fetched_inst, 32'h0);
        end else begin
          want = predicted_results.pop_front();
          if (rsp_if.status !== want.status)
            report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
          if (rsp_if.fetched_inst !== want.fetched_inst)
            report_mismatch("fetched_inst", rsp_if.fetched_inst, want.fetched_inst);
          if (rsp_if.inst_pc !== want.inst_pc)
            report_mismatch("inst_pc", rsp_if.inst_pc, want.inst_pc);
          if (rsp_if.is_wide !== want.is_wide)
            report_mismatch("is_wide", 32'(rsp_if.is_wide), 32'(want.is_wide));
          if (rsp_if.next_pc !== want.next_pc)
            report_mismatch("next_pc", rsp_if.next_pc, want.next_pc);
        end
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, predicted_results.size());
      $display("thumb_fetch_branch_forward test failed");
      $finish;
    end
  end

  // Request driver and result back-pressure, both on the falling edge.
  always @(negedge clk_i) begin
    tfbf_pkg::req_t next_req;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      rsp_if.ready <= 1'b0;
    end else begin
      if (!req_if.valid || req_taken) begin
        if (fetch_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = fetch_queue.pop_front();
          n_sent++;
          req_if.valid       <= 1'b1;
          req_if.thumb_mode  <= next_req.thumb_mode;
          req_if.first_half  <= next_req.first_half;
          req_if.second_half <= next_req.second_half;
          req_if.reg_value   <= next_req.reg_value;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      req_taken = 1'b0;
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void queue_fetch(input logic thumb, input logic [15:0] first,
                                      input logic [15:0] second, input logic [31:0] rv);
    fetch_queue.push_back({thumb, first, second, rv});
  endfunction

  function automatic tfbf_pkg::req_t random_fetch();
    tfbf_pkg::req_t it;
    logic [31:0]    r;
    logic [31:0]    s2;
    int unsigned    pick;
    r = $urandom;
    s2 = $urandom;
    it.thumb_mode  = 1'b1;
    it.first_half  = r[15:0];
    it.second_half = r[31:16];
    it.reg_value   = $urandom;
    pick = $urandom_range(99);
    if (pick < 6) begin
      it.thumb_mode = 1'b0;
    end else if (pick < 16) begin
      it.thumb_mode = 1'($urandom_range(1));
    end else if (pick < 30) begin
      it.first_half = tfbf_pkg::BX_T1_ONES | (16'($urandom_range(15)) << 3);
      case ($urandom_range(3))
        0: it.reg_value = $urandom & 32'h000f_ffff;
        1: it.reg_value = 32'hefff_fffc + 32'($urandom_range(7));
        default: ;
      endcase
    end else if (pick < 42) begin
      it.first_half = {5'b11100, r[10:0]};
    end else if (pick < 52) begin
      it.first_half  = {5'b11110, r[10:0]};
      it.second_half = {2'b10, s2[13], 1'b1, s2[11:0]};
    end else if (pick < 62) begin
      it.first_half  = {5'b11110, r[10:0]};
      it.second_half = {2'b11, s2[13], 1'b1, s2[11:0]};
    end else if (pick < 76) begin
      it.first_half[15:11] = 5'b11101 + 5'($urandom_range(2));
    end else begin
      it.first_half[15:11] = 5'($urandom_range(28));
    end
    return it;
  endfunction

  task automatic write_cfg(input tfbf_pkg::cfg_idx_t idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      tfbf_pkg::CFG_START_PC: begin
        cfg_start_pc = data;
        model_pc = data;
      end
      tfbf_pkg::CFG_HAZARD_PC:   cfg_hazard_pc = data;
      tfbf_pkg::CFG_HAZARD_INST: cfg_hazard_inst = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // every request handed to the bus must have its result checked
  task automatic wait_drained();
    while (fetch_queue.size() != 0 || n_checked != n_sent || predicted_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
      3: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  initial begin
    logic [31:0] start_list[8];
    logic [31:0] hpc_list[8];
    logic [31:0] hinst_list[8];
    int unsigned n_items;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = tfbf_pkg::CFG_START_PC;
    cfg_data_i  = '0;
    req_if.valid       = 1'b0;
    req_if.thumb_mode  = 1'b0;
    req_if.first_half  = '0;
    req_if.second_half = '0;
    req_if.reg_value   = '0;
    rsp_if.ready       = 1'b0;
    cfg_start_pc    = '0;
    cfg_hazard_pc   = '0;
    cfg_hazard_inst = '0;
    model_pc        = '0;
    req_taken       = 1'b0;
    set_idling(0);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: PC at the hazard limit and just over it, both fetch widths,
    // every branch form at its extremes, ARM mode with and without hazard
    write_cfg(tfbf_pkg::CFG_HAZARD_PC, 32'h0000_1000);
    write_cfg(tfbf_pkg::CFG_HAZARD_INST, 32'hdead_beef);
    write_cfg(tfbf_pkg::CFG_START_PC, 32'hf000_0000);
    queue_fetch(1'b1, 16'h0000, 16'h0000, 32'h0000_0000);
    queue_fetch(1'b0, 16'hffff, 16'hffff, 32'hffff_ffff);  // hazard checked before T bit
    queue_fetch(1'b0, 16'hffff, 16'h1234, 32'h0000_0000);
    queue_fetch(1'b1, 16'hffff, 16'hffff, 32'h0000_0000);
    queue_fetch(1'b1, 16'he3ff, 16'h0000, 32'h0000_0000);
    queue_fetch(1'b1, 16'he400, 16'h0000, 32'h0000_0000);
    queue_fetch(1'b1, 16'hf3ff, 16'hbfff, 32'h0000_0000);
    queue_fetch(1'b1, 16'hf000, 16'hf800, 32'h0000_0000);
    queue_fetch(1'b1, 16'hf7ff, 16'hd7ff, 32'h0000_0000);
    queue_fetch(1'b1, 16'he800, 16'h0000, 32'h0000_0000);
    queue_fetch(1'b1, 16'hf000, 16'h0000, 32'h0000_0000);
    queue_fetch(1'b1, 16'h4778, 16'h0000, 32'h0000_0001);
    queue_fetch(1'b1, 16'hf400, 16'h9000, 32'h0000_0000);  // far backward, wraps
    queue_fetch(1'b1, 16'h0000, 16'h0000, 32'h0000_0000);
    queue_fetch(1'b1, 16'h4700, 16'h0000, 32'hffff_ffff);
    queue_fetch(1'b1, 16'h0000, 16'hffff, 32'h0000_0000);
    queue_fetch(1'b1, 16'h4708, 16'h0000, 32'hf000_0001);
    queue_fetch(1'b1, 16'h7fff, 16'h0000, 32'h0000_0000);
    queue_fetch(1'b1, 16'h0000, 16'h0000, 32'h0000_0000);
    queue_fetch(1'b1, 16'h4780, 16'h0000, 32'h1234_5678);  // bit 7 set, not BX
    wait_drained();
    // hazard PC itself over the limit: stays in hazard
    write_cfg(tfbf_pkg::CFG_HAZARD_PC, 32'hffff_ffff);
    write_cfg(tfbf_pkg::CFG_HAZARD_INST, 32'hffff_ffff);
    write_cfg(CFG_UNUSED, 32'h0000_0000);
    write_cfg(tfbf_pkg::CFG_START_PC, 32'hffff_ffff);
    repeat (3) queue_fetch(1'b1, 16'h0000, 16'h0000, 32'h0000_0000);
    wait_drained();

    start_list = '{32'h0000_0000, 32'h0000_8000, 32'hefff_fff0, 32'h0000_0100,
                   32'hffff_ffff, 32'h2000_0000, $urandom, $urandom};
    hpc_list   = '{32'h0000_0000, $urandom & 32'h0fff_fffe, 32'h0000_4000, 32'hf000_0000,
                   32'hffff_ffff, 32'h1000_0000, $urandom & 32'h7fff_ffff, 32'h0000_0000};
    hinst_list = '{32'h0000_0000, 32'hffff_ffff, $urandom, $urandom,
                   32'hffff_ffff, $urandom, 32'h0000_0000, $urandom};
    for (int p = 0; p < 8; p++) begin
      set_idling(p % 4);
      write_cfg(tfbf_pkg::CFG_HAZARD_PC, hpc_list[p]);
      write_cfg(tfbf_pkg::CFG_HAZARD_INST, hinst_list[p]);
      if (p % 3 == 1) write_cfg(CFG_UNUSED, $urandom);
      write_cfg(tfbf_pkg::CFG_START_PC, start_list[p]);
      n_items = (hpc_list[p] > tfbf_pkg::HAZARD_LIMIT) ? 80 : 195;
      for (int i = 0; i < n_items; i++) fetch_queue.push_back(random_fetch());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("%0d requests sent, %0d results checked over 10 configurations", n_accepted,
             n_checked);
    $display("hazards %0d, ARM mode %0d, wide %0d, redirects %0d, mismatches %0d",
             n_hazard, n_arm, n_wide, n_redirect, n_errors);
    if (n_errors == 0 && predicted_results.size() == 0) begin
      $display("thumb_fetch_branch_forward test passed");
    end else begin
      $display("thumb_fetch_branch_forward test failed");
    end
    $finish;
  end

endmodule

@@ thumb_fetch_branch_forward.f @@
+incdir+rtl
rtl/tfbf_pkg.sv
rtl/tfbf_req_if.sv
rtl/tfbf_rsp_if.sv
rtl/thumb_fetch_branch_forward.sv
tb/testbench.sv
